/* src/mbss_pkg.sv */
`timescale 1ns / 1ps
// mbss_pkg: shared constants, register index codes and types for the
// masked byte signature search. No dependencies.
package mbss_pkg;

   // sizing
   localparam int PATTERN_MAX  = 8;
   localparam int OFFSET_BITS  = 16;
   localparam int LEN_CAP      = (PATTERN_MAX < 8) ? PATTERN_MAX : 8;
   localparam int LEN_IDX_BITS = $clog2(LEN_CAP + 1);
   localparam int COUNT_BITS   = 17;

   // register widths
   localparam int PATTERN_BITS = 64;
   localparam int CARE_BITS    = 8;
   localparam int PLEN_BITS    = 4;
   localparam int SLEN_BITS    = 16;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_IDX_BITS  = 2;

   // register reset values
   localparam logic [CARE_BITS-1:0] CARE_RESET = '1;
   localparam logic [PLEN_BITS-1:0] PLEN_RESET = PLEN_BITS'(1);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PATTERN_BYTES  = 2'd0,
      CSR_CARE_MASK      = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2,
      CSR_SEARCH_LENGTH  = 2'd3
   } csr_index_type;

   // sliding window, index 0 holds the newest byte
   typedef struct packed {
      logic [PATTERN_MAX-1:0][7:0] bytes;
      logic [PATTERN_MAX-1:0]      bad;
   } window_type;

   // pattern settings seen by the compare unit
   typedef struct packed {
      logic [PATTERN_BITS-1:0] pattern;
      logic [CARE_BITS-1:0]    care;
      logic [LEN_IDX_BITS-1:0] len;
   } pattern_cfg_type;

endpackage

/* src/mbss_channels.sv */
`timescale 1ns / 1ps
// mbss_req_if / mbss_rsp_if: valid/ready channels of the signature search.
// Depends on mbss_pkg for the offset width.
interface mbss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_unreadable;
   logic       search_start;

   modport source (output valid, data_byte, byte_unreadable, search_start, input ready);
   modport sink   (input valid, data_byte, byte_unreadable, search_start, output ready);
endinterface

interface mbss_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             found;
   logic [mbss_pkg::OFFSET_BITS-1:0] match_offset;

   modport source (output valid, found, match_offset, input ready);
   modport sink   (input valid, found, match_offset, output ready);
endinterface

/* src/mbss_window_cmp.sv */
`timescale 1ns / 1ps
// mbss_window_cmp: masked compare of the updated window against the pattern.
// Depends on mbss_pkg for the window and pattern types.
module mbss_window_cmp (
   input  mbss_pkg::window_type      window,
   input  mbss_pkg::pattern_cfg_type cfg,
   output logic                      match
);

   logic [mbss_pkg::LEN_CAP:0] len_match;

   // one match flag per candidate length; pattern byte k lines up with
   // window slot len-1-k, and a bad byte fails even at a wildcard
   always_comb begin
      len_match = '1;
      for (int n = 1; n <= mbss_pkg::LEN_CAP; n++) begin
         for (int k = 0; k < mbss_pkg::LEN_CAP; k++) begin
            if (k < n) begin
               if (window.bad[n-1-k] ||
                   (cfg.care[k] && (window.bytes[n-1-k] != cfg.pattern[8*k +: 8]))) begin
                  len_match[n] = 1'b0;
               end
            end
         end
      end
   end

   // empty pattern matches trivially
   assign match = len_match[cfg.len];

endmodule

/* src/masked_byte_signature_search_top.sv */
`timescale 1ns / 1ps
// masked_byte_signature_search_top: streaming masked byte signature finder.
// Depends on mbss_pkg, mbss_req_if, mbss_rsp_if and mbss_window_cmp.
//
// Usage:
//   Program the pattern bytes, care mask, pattern length and search length
//   through the csr_ write port while no search result is outstanding.
//   Then stream the searched range one byte per request on the req channel,
//   marking the first byte with search_start. A byte flagged unreadable
//   fails every window that holds it.
//   Each search gives exactly one result on the rsp channel: found with the
//   offset of the first matching window, or not-found once the range is
//   used up (at once on the start byte if the pattern is empty or the range
//   is shorter than the pattern). Bytes sent after a search ends and before
//   the next start are dropped without a result.
//   Latency: a result is shown in the cycle after the request that caused it.
//   Throughput: one request per cycle; the window shift and the parallel
//   compare of up to eight bytes finish within the cycle of the request.
//   The result register frees a slot while it is taken, so requests keep
//   flowing as long as rsp.ready is high; while a result is held back by the
//   receiver, req.ready is low.
//   Reset (synchronous) restores the register defaults, clears the window
//   and leaves the block with no search running and no result pending.
module masked_byte_signature_search_top (
   input  logic                                 clock,
   input  logic                                 reset,
   mbss_req_if.sink                             req,
   mbss_rsp_if.source                           rsp,
   input  logic                                 csr_wr_en,
   input  logic [mbss_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [mbss_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);

   // configuration registers
   logic [mbss_pkg::PATTERN_BITS-1:0] pattern_bytes_ff;
   logic [mbss_pkg::CARE_BITS-1:0]    care_mask_ff;
   logic [mbss_pkg::PLEN_BITS-1:0]    pattern_length_ff;
   logic [mbss_pkg::SLEN_BITS-1:0]    search_length_ff;

   // search state
   mbss_pkg::window_type               window_ff, window_in;
   logic [mbss_pkg::COUNT_BITS-1:0]    bytes_seen_ff, bytes_seen_in;
   logic                               search_done_ff, search_done_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [mbss_pkg::OFFSET_BITS-1:0]   rsp_offset_ff, rsp_offset_in;

   mbss_pkg::window_type               clear_window;
   mbss_pkg::window_type               base_window;
   mbss_pkg::window_type               shift_window;
   mbss_pkg::pattern_cfg_type          cmp_cfg;
   logic [mbss_pkg::COUNT_BITS-1:0]    base_count;
   logic [mbss_pkg::COUNT_BITS-1:0]    count_next;
   logic [mbss_pkg::COUNT_BITS-1:0]    len_wide;
   logic [mbss_pkg::LEN_IDX_BITS-1:0]  eff_len;
   logic                               accept;
   logic                               active;
   logic                               short_range;
   logic                               take_byte;
   logic                               cmp_match;
   logic                               hit;
   logic                               range_end;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         care_mask_ff      <= mbss_pkg::CARE_RESET;
         pattern_length_ff <= mbss_pkg::PLEN_RESET;
         search_length_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (mbss_pkg::csr_index_type'(csr_index))
            mbss_pkg::CSR_PATTERN_BYTES:  pattern_bytes_ff <= csr_wr_data;
            mbss_pkg::CSR_CARE_MASK:
               care_mask_ff <= csr_wr_data[mbss_pkg::CARE_BITS-1:0];
            mbss_pkg::CSR_PATTERN_LENGTH:
               pattern_length_ff <= csr_wr_data[mbss_pkg::PLEN_BITS-1:0];
            mbss_pkg::CSR_SEARCH_LENGTH:
               search_length_ff <= csr_wr_data[mbss_pkg::SLEN_BITS-1:0];
         endcase
      end
   end

   // pattern length saturates at what the window holds
   assign eff_len = (pattern_length_ff > mbss_pkg::PLEN_BITS'(mbss_pkg::LEN_CAP)) ?
                    mbss_pkg::LEN_IDX_BITS'(mbss_pkg::LEN_CAP) :
                    mbss_pkg::LEN_IDX_BITS'(pattern_length_ff);
   assign len_wide = mbss_pkg::COUNT_BITS'(eff_len);

   // handshake: the result register empties while it is taken
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // window as it stands before this byte, cleared on a start
   always_comb begin
      clear_window.bytes = '0;
      clear_window.bad   = '1;
   end

   assign base_window = req.search_start ? clear_window : window_ff;
   assign base_count  = req.search_start ? '0 : bytes_seen_ff;
   assign active      = req.search_start || !search_done_ff;
   assign short_range = req.search_start &&
                        ((eff_len == '0) ||
                         (mbss_pkg::COUNT_BITS'(search_length_ff) < len_wide));
   assign take_byte   = active && !short_range;

   // shift the new byte into slot 0
   always_comb begin
      shift_window.bytes[0] = req.data_byte;
      shift_window.bad[0]   = req.byte_unreadable;
      for (int i = 1; i < mbss_pkg::PATTERN_MAX; i++) begin
         shift_window.bytes[i] = base_window.bytes[i-1];
         shift_window.bad[i]   = base_window.bad[i-1];
      end
   end

   assign count_next = base_count + mbss_pkg::COUNT_BITS'(1);

   assign cmp_cfg.pattern = pattern_bytes_ff;
   assign cmp_cfg.care    = care_mask_ff;
   assign cmp_cfg.len     = eff_len;

   mbss_window_cmp u_cmp (
      .window (shift_window),
      .cfg    (cmp_cfg),
      .match  (cmp_match)
   );

   assign hit       = cmp_match && (count_next >= len_wide);
   assign range_end = count_next >= mbss_pkg::COUNT_BITS'(search_length_ff);

   // next search state and result
   always_comb begin
      window_in      = window_ff;
      bytes_seen_in  = bytes_seen_ff;
      search_done_in = search_done_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_found_in   = rsp_found_ff;
      rsp_offset_in  = rsp_offset_ff;
      if (accept) begin
         priority if (short_range) begin
            window_in      = clear_window;
            bytes_seen_in  = '0;
            search_done_in = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_found_in   = 1'b0;
            rsp_offset_in  = '0;
         end else if (take_byte) begin
            window_in     = shift_window;
            bytes_seen_in = count_next;
            if (hit) begin
               search_done_in = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_found_in   = 1'b1;
               rsp_offset_in  = mbss_pkg::OFFSET_BITS'(count_next - len_wide);
            end else if (range_end) begin
               search_done_in = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_found_in   = 1'b0;
               rsp_offset_in  = '0;
            end else begin
               search_done_in = 1'b0;
            end
         end else begin
            // byte outside a search is dropped
            search_done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= clear_window;
         bytes_seen_ff  <= '0;
         search_done_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_ff      <= window_in;
         bytes_seen_ff  <= bytes_seen_in;
         search_done_ff <= search_done_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.found        = rsp_found_ff;
   assign rsp.match_offset = rsp_offset_ff;

endmodule

/* src/mbss_checker.sv */
`timescale 1ns / 1ps
// mbss_checker: port-level assertions for the signature search top level,
// attached by bind. Depends on mbss_pkg and masked_byte_signature_search_top.
module mbss_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_found,
   input logic [mbss_pkg::OFFSET_BITS-1:0] rsp_match_offset
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
                                  $stable(rsp_match_offset))
      else $error("stalled result changed");

   // a new result only follows an accepted request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without request");

   // a held result blocks further requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   // reset leaves no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind masked_byte_signature_search_top mbss_checker u_mbss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_found        (rsp.found),
   .rsp_match_offset (rsp.match_offset)
);

/* sim/mbss_search_checker.sv */
`timescale 1ns / 1ps
// mbss_search_checker: watches the request, result and csr ports of the signature
// search, predicts every search outcome and compares it with the results taken.
// Depends on mbss_pkg, mbss_req_if and mbss_rsp_if.
module mbss_search_checker
   import mbss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   mbss_req_if                      req,
   mbss_rsp_if                      rsp,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wr_data,
   output int                       mismatch_total,
   output int                       results_due,
   output logic                     search_active
);

   typedef struct packed {
      logic                   found;
      logic [OFFSET_BITS-1:0] offset;
   } search_outcome_t;

   // outcomes predicted but not yet taken from the result channel
   search_outcome_t due_outcomes[$];
   search_outcome_t want;

   // shadow of the csr registers
   logic [PATTERN_BITS-1:0] sig_bytes;
   logic [CARE_BITS-1:0]    sig_care;
   logic [PLEN_BITS-1:0]    sig_len;
   logic [SLEN_BITS-1:0]    range_len;

   // predicted search state, index 0 holds the newest byte
   logic [7:0]            win_byte [PATTERN_MAX];
   logic                  win_bad  [PATTERN_MAX];
   logic [COUNT_BITS-1:0] seen_count;
   logic                  idle_flag;

   function automatic void clear_window();
      for (int k = 0; k < PATTERN_MAX; k++) begin
         win_byte[k] = '0;
         win_bad[k]  = 1'b1;
      end
      seen_count = '0;
   endfunction

   function automatic void post_outcome(input logic f, input logic [OFFSET_BITS-1:0] off);
      search_outcome_t o;
      o.found  = f;
      o.offset = off;
      due_outcomes.push_back(o);
      idle_flag = 1'b1;
   endfunction

   // one accepted byte of the searched range
   function automatic void advance_search(input logic [7:0] b, input logic bad,
                                          input logic st);
      int         len;
      bit         hit;
      logic [7:0] pat_byte;
      len = (sig_len > LEN_CAP) ? LEN_CAP : int'(sig_len);
      // a start byte clears the window; too short a range ends at once
      if (st) begin
         clear_window();
         idle_flag = 1'b0;
         if (len == 0 || int'(range_len) < len) begin
            post_outcome(1'b0, '0);
            return;
         end
      end
      if (idle_flag)
         return;
      for (int k = PATTERN_MAX - 1; k > 0; k--) begin
         win_byte[k] = win_byte[k-1];
         win_bad[k]  = win_bad[k-1];
      end
      win_byte[0] = b;
      win_bad[0]  = bad;
      seen_count  = seen_count + 1'b1;
      // oldest window byte lines up with pattern byte 0
      if (int'(seen_count) >= len) begin
         hit = 1'b1;
         for (int k = 0; k < len; k++) begin
            pat_byte = sig_bytes[8*k +: 8];
            if (win_bad[len-1-k] || (sig_care[k] && win_byte[len-1-k] != pat_byte))
               hit = 1'b0;
         end
         if (hit) begin
            post_outcome(1'b1, OFFSET_BITS'(int'(seen_count) - len));
            return;
         end
      end
      // last window of the range without a match
      if (seen_count >= range_len)
         post_outcome(1'b0, '0);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         sig_bytes = '0;
         sig_care  = CARE_RESET;
         sig_len   = PLEN_RESET;
         range_len = '0;
         clear_window();
         idle_flag = 1'b1;
         due_outcomes.delete();
         mismatch_total = 0;
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_PATTERN_BYTES:  sig_bytes = csr_wr_data[PATTERN_BITS-1:0];
               CSR_CARE_MASK:      sig_care  = csr_wr_data[CARE_BITS-1:0];
               CSR_PATTERN_LENGTH: sig_len   = csr_wr_data[PLEN_BITS-1:0];
               CSR_SEARCH_LENGTH:  range_len = csr_wr_data[SLEN_BITS-1:0];
               default: ;
            endcase
         end
         // results come from earlier requests, so compare before predicting
         if (rsp.valid && rsp.ready) begin
            if (due_outcomes.size() == 0) begin
               if (mismatch_total < 10)
                  $display("%0t: unexpected result found=%0d offset=%0d",
                           $time, rsp.found, rsp.match_offset);
               mismatch_total++;
            end else begin
               want = due_outcomes.pop_front();
               if (want.found !== rsp.found || want.offset !== rsp.match_offset) begin
                  if (mismatch_total < 10)
                     $display("%0t: result mismatch: expected found=%0d offset=%0d, got found=%0d offset=%0d",
                              $time, want.found, want.offset, rsp.found, rsp.match_offset);
                  mismatch_total++;
               end
            end
         end
         if (req.valid && req.ready)
            advance_search(req.data_byte, req.byte_unreadable, req.search_start);
      end
      results_due   = due_outcomes.size();
      search_active = !idle_flag;
   end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for masked_byte_signature_search_top; directed
// searches, then random settings and byte streams. Depends on mbss_pkg, the
// channel interfaces, the block itself and mbss_search_checker.
module tb_top;
   import mbss_pkg::*;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wr_data;

   mbss_req_if req_ch ();
   mbss_rsp_if rsp_ch ();

   int   mismatches;
   int   results_due;
   logic search_active;

   // stimulus knobs and the settings last programmed
   bit                      quiet;
   bit                      rsp_calm;
   int                      send_gap_odds;
   int                      items_sent;
   logic [PATTERN_BITS-1:0] cur_pattern;
   logic [CARE_BITS-1:0]    cur_care;
   logic [PLEN_BITS-1:0]    cur_plen;
   logic [SLEN_BITS-1:0]    cur_slen;

   masked_byte_signature_search_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   mbss_search_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_total (mismatches),
      .results_due    (results_due),
      .search_active  (search_active)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // run limit
   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // result receiver with random stall bursts
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && !rsp_calm && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // one csr write, called at a falling edge
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [PATTERN_BITS-1:0] pat,
                                input logic [CARE_BITS-1:0] care,
                                input logic [PLEN_BITS-1:0] plen,
                                input logic [SLEN_BITS-1:0] slen);
      csr_write(CSR_PATTERN_BYTES, pat);
      csr_write(CSR_CARE_MASK, CSR_DATA_BITS'(care));
      csr_write(CSR_PATTERN_LENGTH, CSR_DATA_BITS'(plen));
      csr_write(CSR_SEARCH_LENGTH, CSR_DATA_BITS'(slen));
      csr_wr_en   <= 1'b0;
      cur_pattern = pat;
      cur_care    = care;
      cur_plen    = plen;
      cur_slen    = slen;
   endtask

   // one byte request; starts and ends at a falling edge
   task automatic put_byte(input logic [7:0] b, input logic bad, input logic st);
      items_sent++;
      if (!quiet && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.data_byte       <= b;
      req_ch.byte_unreadable <= bad;
      req_ch.search_start    <= st;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // stop sending and let every outcome and the block itself drain
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // one search with the pattern planted at a random offset; a closing search
   // keeps going until the search is over, others may stop short or overrun
   task automatic run_search(input bit closing);
      int         len;
      int         n_bytes;
      int         pos;
      int         max_pos;
      int         i;
      bit         embed;
      logic [7:0] b;
      logic       bad;
      len   = (cur_plen > 8) ? 8 : int'(cur_plen);
      embed = closing || $urandom_range(0, 2) != 0;
      if (closing) begin
         max_pos = (len > 0 && int'(cur_slen) >= len) ? int'(cur_slen) - len : 0;
         pos     = $urandom_range(0, (max_pos > 30) ? 30 : max_pos);
      end else begin
         pos = $urandom_range(0, 30);
      end
      n_bytes = $urandom_range(1, (cur_slen < 45) ? int'(cur_slen) + 3 : 48);
      i = 0;
      do begin
         b   = 8'($urandom);
         bad = ($urandom_range(0, 15) == 0) && !(closing && i >= pos);
         if (embed && i >= pos && i < pos + len && cur_care[i-pos])
            b = cur_pattern[8*(i-pos) +: 8];
         put_byte(b, bad, i == 0);
         i++;
      end while (closing ? search_active : (i < n_bytes));
   endtask

   // random settings, then a few searches with the last one run to its end
   task automatic random_phase();
      int                      n_search;
      logic [PATTERN_BITS-1:0] pat;
      logic [CARE_BITS-1:0]    care;
      logic [PLEN_BITS-1:0]    plen;
      logic [SLEN_BITS-1:0]    slen;
      pat = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: pat = '0;
         1: pat = '1;
         default: ;
      endcase
      case ($urandom_range(0, 5))
         0: care = 8'h00;
         1: care = 8'hFF;
         default: care = CARE_BITS'($urandom);
      endcase
      case ($urandom_range(0, 19))
         0: plen = 4'd0;
         1: plen = PLEN_BITS'($urandom_range(9, 15));
         2: plen = 4'd8;
         3: plen = 4'd1;
         default: plen = PLEN_BITS'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 19))
         0: slen = 16'd0;
         1: slen = 16'hFFFF;
         2: slen = SLEN_BITS'($urandom_range(0, 65535));
         default: slen = SLEN_BITS'($urandom_range(0, 40));
      endcase
      load_settings(pat, care, plen, slen);
      send_gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
      rsp_calm      = ($urandom_range(0, 3) == 0);
      n_search      = $urandom_range(1, 6);
      for (int s = 0; s < n_search; s++) begin
         // stray bytes without a start
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
               put_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
         run_search(s == n_search - 1);
      end
      settle();
   endtask

   initial begin
      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_index              = CSR_PATTERN_BYTES;
      csr_wr_data            = '0;
      req_ch.valid           = 1'b0;
      req_ch.data_byte       = '0;
      req_ch.byte_unreadable = 1'b0;
      req_ch.search_start    = 1'b0;
      quiet                  = 1'b0;
      rsp_calm               = 1'b0;
      send_gap_odds          = 4;
      items_sent             = 0;
      cur_pattern            = '0;
      cur_care               = CARE_RESET;
      cur_plen               = PLEN_RESET;
      cur_slen               = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: empty range ends at the start byte, then an idle byte
      put_byte(8'h00, 1'b0, 1'b1);
      put_byte(8'hFF, 1'b0, 1'b0);
      settle();

      // full eight byte pattern found at offset 2 on the last window
      load_settings(64'hFF00_5AA5_0102_80FF, 8'hFF, 4'd8, 16'd10);
      put_byte(8'h11, 1'b0, 1'b1);
      put_byte(8'h22, 1'b0, 1'b0);
      for (int k = 0; k < 8; k++)
         put_byte(cur_pattern[8*k +: 8], 1'b0, 1'b0);
      settle();

      // zero pattern length ends at the start byte
      load_settings(64'h0123_4567_89AB_CDEF, 8'h5A, 4'd0, 16'd20);
      put_byte(8'h5A, 1'b0, 1'b1);
      settle();

      // saturated length, all wildcards: unreadable first byte pushes match to 1
      load_settings('1, 8'h00, 4'd15, 16'd9);
      put_byte(8'hC3, 1'b1, 1'b1);
      for (int k = 0; k < 8; k++)
         put_byte(8'($urandom), 1'b0, 1'b0);
      settle();

      // random part, no idling near the end
      while (items_sent < 1100) begin
         if (items_sent >= 950)
            quiet = 1'b1;
         random_phase();
      end
      settle();
      repeat (10) @(negedge clock);

      if (mismatches == 0 && results_due == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* masked_byte_signature_search_top.f */
src/mbss_pkg.sv
src/mbss_channels.sv
src/mbss_window_cmp.sv
src/masked_byte_signature_search_top.sv
src/mbss_checker.sv
sim/mbss_search_checker.sv
sim/tb_top.sv
